/* rtl/fcr_pkg.sv */
// Shared constants and types for the feedback comb reverb.
package fcr_pkg;

    // Default sizes of the echo line and the audio samples.
    localparam int MAX_DELAY_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int DELAY_BITS     = 13;
    localparam int GAIN_BITS      = 16;
    localparam int FRAC_BITS      = 15;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN  = 2'd1;

    // Configuration reset values.
    localparam logic [DELAY_BITS-1:0]       DELAY_RESET = 13'd1;
    localparam logic signed [GAIN_BITS-1:0] GAIN_RESET  = 16'sd16384;

    // Control handed from the address generator to the arithmetic stage.
    typedef struct packed {
        logic load;
        logic use_echo;
    } issue_t;

endpackage

/* rtl/feedback_comb_reverb.sv */
// Top level of the streaming feedback comb reverb.
//
// Each input beat carries one audio sample and a last_of_sound flag; each
// output beat carries y = x + ((g * y_old) >>> 15), saturated, and a clipped flag.
// y_old is the output produced delay_samples beats earlier in the same sound.
// For the first delay_samples beats of a sound the sample passes unchanged.
// Both streams use valid/ready. The configuration channel writes register 0
// (delay_samples) or register 1 (feedback_gain); it is always ready, and it is
// meant to be written only while no beat is in flight.
// An accepted input beat is registered in the arithmetic stage and then in the
// output register. Throughput is one beat per cycle while out_ready stays high:
// the echo line is one RAM with one read and one write per beat, and a delay of
// one is served by forwarding the output register into the multiply-add.
// Reset clears the write pointer, the warm-up count and the pipeline, and loads
// delay_samples = 1 and feedback_gain = 0.5. The echo line needs no clearing:
// an entry is read only after it has been written in the current sound.
// When the receiver stalls, the output register holds its beat; one more beat
// can wait in the arithmetic stage, after which in_ready drops.
module feedback_comb_reverb
    import fcr_pkg::*;
    #(
        parameter int MAX_DELAY   = MAX_DELAY_DEF,
        parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
    )
    (
        input  logic                          clk,
        input  logic                          rst_n,
        input  logic                          in_valid,
        output logic                          in_ready,
        input  logic signed [SAMPLE_BITS-1:0] in_sample,
        input  logic                          last_of_sound,
        output logic                          out_valid,
        input  logic                          out_ready,
        output logic signed [SAMPLE_BITS-1:0] out_sample,
        output logic                          clipped,
        input  logic                          cfg_valid,
        output logic                          cfg_ready,
        input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
        input  logic [CFG_DATA_BITS-1:0]      cfg_data
    );

    localparam int AW = $clog2(MAX_DELAY);

    logic                        accept;
    logic                        s1_free;
    issue_t                      issue;
    logic                        use_echo;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic signed [GAIN_BITS-1:0] gain;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [SAMPLE_BITS-1:0]      ram_wdata;
    logic [SAMPLE_BITS-1:0]      ram_rdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = s1_free;
    assign accept    = in_valid && in_ready;

    assign issue.load     = accept;
    assign issue.use_echo = use_echo;

    // Pointer, warm-up count and the address of the echo to read.
    fcr_addr_gen
        #(
            .MAX_DELAY (MAX_DELAY)
        )
        u_addr_gen
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .cfg_write     (cfg_valid && cfg_ready),
            .cfg_index     (cfg_index),
            .cfg_data      (cfg_data),
            .accept        (accept),
            .last_of_sound (last_of_sound),
            .rd_addr       (rd_addr),
            .wr_addr       (wr_addr),
            .use_echo      (use_echo),
            .gain          (gain)
        );

    // The echo line: read when a beat is accepted, written when it leaves
    // the arithmetic stage.
    fcr_ram
        #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (MAX_DELAY)
        )
        u_echo_line
        (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (accept),
            .raddr (rd_addr),
            .rdata (ram_rdata)
        );

    fcr_mac
        #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AW          (AW)
        )
        u_mac
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .issue      (issue),
            .in_x       (in_sample),
            .rd_addr    (rd_addr),
            .wr_addr    (wr_addr),
            .gain       (gain),
            .ram_rdata  (ram_rdata),
            .out_ready  (out_ready),
            .s1_free    (s1_free),
            .ram_we     (ram_we),
            .ram_waddr  (ram_waddr),
            .ram_wdata  (ram_wdata),
            .out_valid  (out_valid),
            .out_sample (out_sample),
            .clipped    (clipped)
        );

endmodule

/* rtl/fcr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module fcr_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 4096
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fcr_addr_gen.sv */
// Configuration registers, write pointer, warm-up counter and echo read address.
module fcr_addr_gen
    import fcr_pkg::*;
    #(
        parameter int MAX_DELAY = MAX_DELAY_DEF
    )
    (
        input  logic                            clk,
        input  logic                            rst_n,
        input  logic                            cfg_write,
        input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
        input  logic [CFG_DATA_BITS-1:0]        cfg_data,
        input  logic                            accept,
        input  logic                            last_of_sound,
        output logic [$clog2(MAX_DELAY)-1:0]    rd_addr,
        output logic [$clog2(MAX_DELAY)-1:0]    wr_addr,
        output logic                            use_echo,
        output logic signed [GAIN_BITS-1:0]     gain
    );

    localparam int AW = $clog2(MAX_DELAY);
    localparam int CW = $clog2(MAX_DELAY + 1);
    localparam int DW = (CW > DELAY_BITS) ? CW : DELAY_BITS;
    localparam int SW = DW + 1;

    logic [DELAY_BITS-1:0]       delay_reg;
    logic signed [GAIN_BITS-1:0] gain_reg;
    logic [AW-1:0]               wp_reg;
    logic [AW-1:0]               wp_next;
    logic [CW-1:0]               warm_reg;
    logic [CW-1:0]               warm_next;
    logic [DW-1:0]               delay_ext;
    logic [DW-1:0]               delay_eff;
    logic [SW-1:0]               rd_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DELAY: delay_reg <= cfg_data[DELAY_BITS-1:0];
                CFG_GAIN:  gain_reg  <= $signed(cfg_data[GAIN_BITS-1:0]);
                default:   ;
            endcase
        end
    end

    // A delay of zero acts as one, and a delay beyond the line acts as its length.
    always_comb
    begin
        delay_ext = DW'(delay_reg);
        if (delay_ext == '0)
        begin
            delay_eff = DW'(1);
        end
        else if (delay_ext > DW'(MAX_DELAY))
        begin
            delay_eff = DW'(MAX_DELAY);
        end
        else
        begin
            delay_eff = delay_ext;
        end
    end

    always_comb
    begin
        if (SW'(wp_reg) >= SW'(delay_eff))
        begin
            rd_wide = SW'(wp_reg) - SW'(delay_eff);
        end
        else
        begin
            rd_wide = SW'(wp_reg) + SW'(MAX_DELAY) - SW'(delay_eff);
        end
    end

    assign rd_addr  = rd_wide[AW-1:0];
    assign wr_addr  = wp_reg;
    assign use_echo = DW'(warm_reg) >= delay_eff;
    assign gain     = gain_reg;

    always_comb
    begin
        wp_next = (wp_reg == AW'(MAX_DELAY - 1)) ? '0 : wp_reg + AW'(1);
        if (last_of_sound)
        begin
            warm_next = '0;
        end
        else if (warm_reg < CW'(MAX_DELAY))
        begin
            warm_next = warm_reg + CW'(1);
        end
        else
        begin
            warm_next = warm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            warm_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            warm_reg <= warm_next;
        end
    end

endmodule

/* rtl/fcr_mac.sv */
// Feedback multiply-add with saturation, echo forwarding and the output register.
module fcr_mac
    import fcr_pkg::*;
    #(
        parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
        parameter int AW          = 12
    )
    (
        input  logic                          clk,
        input  logic                          rst_n,
        input  issue_t                        issue,
        input  logic signed [SAMPLE_BITS-1:0] in_x,
        input  logic [AW-1:0]                 rd_addr,
        input  logic [AW-1:0]                 wr_addr,
        input  logic signed [GAIN_BITS-1:0]   gain,
        input  logic [SAMPLE_BITS-1:0]        ram_rdata,
        input  logic                          out_ready,
        output logic                          s1_free,
        output logic                          ram_we,
        output logic [AW-1:0]                 ram_waddr,
        output logic [SAMPLE_BITS-1:0]        ram_wdata,
        output logic                          out_valid,
        output logic signed [SAMPLE_BITS-1:0] out_sample,
        output logic                          clipped
    );

    localparam int PW = SAMPLE_BITS + GAIN_BITS;
    localparam int QW = PW - FRAC_BITS;
    localparam int SUMW = SAMPLE_BITS + 2;
    localparam logic signed [SUMW-1:0] SUM_MAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SUM_MIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    logic                          s1_valid_reg;
    logic                          s1_echo_reg;
    logic                          s1_fwd_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [AW-1:0]                 s1_waddr_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          clipped_reg;

    logic                          advance;
    logic signed [SAMPLE_BITS-1:0] echo;
    logic signed [PW-1:0]          prod;
    logic signed [QW-1:0]          scaled;
    logic signed [SUMW-1:0]        sum;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          clip_next;

    assign advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free = !s1_valid_reg || advance;

    // The entry written in the cycle of the read is not yet in the read data;
    // it still sits in the output register.
    assign echo   = s1_fwd_reg ? out_sample_reg : $signed(ram_rdata);
    assign prod   = echo * gain;
    assign scaled = prod[PW-1:FRAC_BITS];
    assign sum    = SUMW'(s1_x_reg) + SUMW'(scaled);

    always_comb
    begin
        y_next    = s1_x_reg;
        clip_next = 1'b0;
        if (s1_echo_reg)
        begin
            if (sum > SUM_MAX)
            begin
                y_next    = SUM_MAX[SAMPLE_BITS-1:0];
                clip_next = 1'b1;
            end
            else if (sum < SUM_MIN)
            begin
                y_next    = SUM_MIN[SAMPLE_BITS-1:0];
                clip_next = 1'b1;
            end
            else
            begin
                y_next = sum[SAMPLE_BITS-1:0];
            end
        end
    end

    assign ram_we    = advance;
    assign ram_waddr = s1_waddr_reg;
    assign ram_wdata = y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue.load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.load)
        begin
            s1_echo_reg  <= issue.use_echo;
            s1_fwd_reg   <= ram_we && (ram_waddr == rd_addr);
            s1_x_reg     <= in_x;
            s1_waddr_reg <= wr_addr;
        end
        if (advance)
        begin
            out_sample_reg <= y_next;
            clipped_reg    <= clip_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign clipped    = clipped_reg;

endmodule

/* test/feedback_comb_reverb_tb.sv */
// Self-checking testbench for the feedback comb reverb: directed and random audio streams.
module feedback_comb_reverb_tb;

    import fcr_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int MD = MAX_DELAY_DEF;

    // The register map decodes two index bits; these two indexes hold no register
    // and writes to them must leave the configuration alone.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

    // Generous bound on the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 400000;

    // One input beat as it waits for the driver.
    typedef struct {
        logic signed [SB-1:0] sample;
        logic                 last;
    } sound_item_t;

    // One output beat as the filter should produce it.
    typedef struct {
        logic signed [SB-1:0] sample;
        logic                 clip;
    } echo_beat_t;

    // Clock, reset and every block input start at known values.
    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_ready;
    logic signed [SB-1:0]      in_sample     = '0;
    logic                      last_of_sound = 1'b0;
    logic                      out_valid;
    logic                      out_ready     = 1'b0;
    logic signed [SB-1:0]      out_sample;
    logic                      clipped;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

    // Stimulus waiting to be sent and the outputs the filter still owes us.
    sound_item_t pending_q [$];
    echo_beat_t  echo_expect_q [$];

    // Our own copy of the filter state. The echo memory mirrors the block's delay
    // line; the write pointer and the warm-up count follow the same rules.
    logic signed [SB-1:0]        echo_mem [MD];
    int                          wr_ptr    = 0;
    int                          warm_cnt  = 0;
    logic [DELAY_BITS-1:0]       delay_reg = DELAY_RESET;
    logic signed [GAIN_BITS-1:0] gain_reg  = GAIN_RESET;

    // Idle rates in percent, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Bookkeeping for the end of the run.
    int queued_cnt   = 0;
    int accepted_cnt = 0;
    int result_cnt   = 0;
    int clip_cnt     = 0;
    int sound_cnt    = 0;
    int cfg_cnt      = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    feedback_comb_reverb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_sample     (in_sample),
        .last_of_sound (last_of_sound),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_sample    (out_sample),
        .clipped       (clipped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Run one accepted input beat through the comb filter and queue the output
    // it must produce. Out-of-range delays are clamped the same way the block
    // clamps them: zero behaves as one, anything above the line length as the
    // full line length.
    function automatic void comb_filter_predict(input logic signed [SB-1:0] x,
                                                input logic last);
        int         d;
        int         rd;
        int         prod;
        int         sum;
        echo_beat_t beat;
        d = delay_reg;
        if (d == 0)
            d = 1;
        if (d > MD)
            d = MD;
        beat.sample = x;
        beat.clip   = 1'b0;
        // Once the current sound has seen at least d samples, the entry d slots
        // back was written in this sound and the echo is added.
        if (warm_cnt >= d)
        begin
            rd   = (wr_ptr + MD - d) % MD;
            prod = gain_reg * echo_mem[rd];
            // An arithmetic shift of the signed product rounds toward minus infinity.
            sum  = x + (prod >>> FRAC_BITS);
            if (sum > (2 ** (SB - 1)) - 1)
            begin
                sum       = (2 ** (SB - 1)) - 1;
                beat.clip = 1'b1;
            end
            else if (sum < -(2 ** (SB - 1)))
            begin
                sum       = -(2 ** (SB - 1));
                beat.clip = 1'b1;
            end
            beat.sample = SB'(sum);
        end
        echo_mem[wr_ptr] = beat.sample;
        wr_ptr = (wr_ptr + 1) % MD;
        // The warm-up count restarts after the last sample of a sound and
        // otherwise saturates at the line length.
        if (last)
            warm_cnt = 0;
        else if (warm_cnt < MD)
            warm_cnt = warm_cnt + 1;
        echo_expect_q.push_back(beat);
    endfunction

    function automatic void queue_sample(input logic signed [SB-1:0] x, input logic last);
        sound_item_t item;
        item.sample = x;
        item.last   = last;
        pending_q.push_back(item);
        queued_cnt = queued_cnt + 1;
        if (last)
            sound_cnt = sound_cnt + 1;
    endfunction

    // Full-scale values, quiet values near zero and uniformly random values, so
    // that both saturation and long decaying echoes show up.
    function automatic logic signed [SB-1:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return $urandom_range(1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
        else if (pick < 3)
            return SB'(int'($urandom_range(512)) - 256);
        else
            return SB'($urandom);
    endfunction

    // Queue whole sounds of random length, the final one cut to fit the count.
    // Short sounds restart the warm-up often; long ones let the echo build up.
    task automatic add_sounds(input int n_items, input int max_len);
        int left;
        int len;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(max_len, 1);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
                queue_sample(rand_sample(), i == len - 1);
            left = left - len;
        end
    endtask

    // Block until every queued beat went in and every expected beat came out,
    // then leave a few spare cycles for the two-stage pipeline.
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || echo_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write. The valid stays high when another write follows, so
    // only the caller lowers it once the last write has gone through.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_cnt = cfg_cnt + 1;
        case (idx)
            CFG_DELAY: delay_reg = data[DELAY_BITS-1:0];
            CFG_GAIN:  gain_reg  = data;
            default:   ;
        endcase
    endtask

    // Load both registers; with spare set, also hit the two unused indexes with
    // random data, which must change nothing.
    task automatic configure(input logic [CFG_DATA_BITS-1:0] delay_word,
                             input logic [CFG_DATA_BITS-1:0] gain_word,
                             input logic spare);
        write_reg(CFG_DELAY, delay_word);
        if (spare)
        begin
            write_reg(CFG_SPARE_A, CFG_DATA_BITS'($urandom));
            write_reg(CFG_SPARE_B, CFG_DATA_BITS'($urandom));
        end
        write_reg(CFG_GAIN, gain_word);
        cfg_valid <= 1'b0;
    endtask

    // Driver: presents pending beats, holding each one until it is taken, and
    // predicts the output of every beat at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                comb_filter_predict(in_sample, last_of_sound);
                accepted_cnt = accepted_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid      <= 1'b1;
                    in_sample     <= pending_q[0].sample;
                    last_of_sound <= pending_q[0].last;
                    pending_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output beat against the oldest expectation and
    // throttles the output with a random ready.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_cnt = result_cnt + 1;
                if (clipped === 1'b1)
                    clip_cnt = clip_cnt + 1;
                if (echo_expect_q.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("ERROR: output beat %0d with none expected: sample %0d clipped %b",
                                 result_cnt, out_sample, clipped);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                else
                begin
                    if (out_sample !== echo_expect_q[0].sample ||
                        clipped !== echo_expect_q[0].clip)
                    begin
                        if (mismatch_cnt < 10)
                            $display("ERROR: beat %0d: expected %0d/%b, got %0d/%b",
                                     result_cnt, echo_expect_q[0].sample, echo_expect_q[0].clip,
                                     out_sample, clipped);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                    echo_expect_q.pop_front();
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("feedback_comb_reverb test failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        logic [CFG_DATA_BITS-1:0] delay_word;
        logic [CFG_DATA_BITS-1:0] gain_word;
        int                       pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The sender idles often and the receiver even more during the
        // directed part and the first random phase.
        send_idle_pct = 23;
        recv_idle_pct = 46;

        // Reset settings, delay one and gain one half: warm-up pass-through,
        // positive saturation, a full-scale negative input, negative saturation on the
        // last sample, then a fresh two-sample sound.
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd1, 1'b1);
        wait_idle();

        // Most negative gain. Minus one times minus one overflows the Q1.15 range
        // and gives +32768, so the sum clips; another beat lands exactly on the
        // negative limit without clipping. Unused indexes are written as well.
        configure(16'd1, 16'h8000, 1'b1);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(-16'sd2, 1'b1);
        wait_idle();

        // A delay of zero must behave as a delay of one; largest positive gain.
        configure(16'd0, 16'h7FFF, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sd12345, 1'b1);
        wait_idle();

        // Upper bits of the delay word lie outside the 13-bit register and are
        // dropped, leaving a delay of three; zero gain makes the echo vanish.
        configure(16'hE003, 16'h0000, 1'b1);
        queue_sample(16'sd100, 1'b0);
        queue_sample(16'sd200, 1'b0);
        queue_sample(16'sd300, 1'b0);
        queue_sample(16'sd400, 1'b0);
        queue_sample(-16'sd500, 1'b1);
        wait_idle();

        // Negative half gain: odd products exercise rounding toward minus infinity.
        configure(16'd3, 16'hC000, 1'b0);
        queue_sample(16'sd7, 1'b0);
        queue_sample(-16'sd7, 1'b0);
        queue_sample(16'sd1, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        wait_idle();

        // Random part: three phases of five segments, each segment with its own
        // delay and gain. Delays stay short so that sounds run well past their
        // warm-up and the echo feeds back many times.
        for (int seg = 0; seg < 15; seg++)
        begin
            if (seg == 5)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 23;
            end
            else if (seg == 10)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(7);
            delay_word = {3'($urandom), 13'($urandom_range(48, 1))};
            if (pick == 0)
                delay_word = {3'($urandom), 13'd0};
            else if (pick == 1)
                delay_word = {3'($urandom), 13'd1};
            pick = $urandom_range(7);
            gain_word = CFG_DATA_BITS'($urandom);
            if (pick == 0)
                gain_word = 16'h7FFF;
            else if (pick == 1)
                gain_word = 16'h8000;
            configure(delay_word, gain_word, seg % 4 == 0);
            add_sounds(90, 80);
            wait_idle();
        end

        // Longest delay: the sound stays far shorter than the line, so every
        // sample is still in its warm-up and passes through unchanged.
        configure(16'd4096, 16'd24000, 1'b0);
        for (int i = 0; i < 60; i++)
            queue_sample(rand_sample(), 1'b0);
        wait_idle();

        // Same sound continues under a delay above the line length, which is
        // clamped to the line length and so still passes through, then zero
        // (acts as one), then 40. The sound has already seen more samples than
        // either of the last two delays, so those echo at once.
        configure(16'h1FFF, 16'hB1E0, 1'b0);
        for (int i = 0; i < 20; i++)
            queue_sample(rand_sample(), 1'b0);
        wait_idle();
        configure(16'd0, 16'd30000, 1'b0);
        for (int i = 0; i < 20; i++)
            queue_sample(rand_sample(), 1'b0);
        wait_idle();
        configure(16'd40, 16'h9000, 1'b0);
        for (int i = 0; i < 20; i++)
            queue_sample(rand_sample(), i == 19);
        wait_idle();

        // Delay raised mid-sound above the samples seen so far: the output must
        // go back to pass-through until the sound is long enough again.
        configure(16'd5, 16'd16384, 1'b0);
        for (int i = 0; i < 10; i++)
            queue_sample(rand_sample(), 1'b0);
        wait_idle();
        configure(16'd20, 16'd16384, 1'b0);
        for (int i = 0; i < 40; i++)
            queue_sample(rand_sample(), i == 39);
        wait_idle();

        repeat (10) @(posedge clk);

        $display("Sent %0d samples in %0d complete sounds and checked %0d output beats.",
                 accepted_cnt, sound_cnt, result_cnt);
        $display("Register writes: %0d; clipped outputs: %0d; mismatches: %0d.",
                 cfg_cnt, clip_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("feedback_comb_reverb test passed");
        else
            $display("feedback_comb_reverb test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fcr_pkg.sv
rtl/fcr_ram.sv
rtl/fcr_addr_gen.sv
rtl/fcr_mac.sv
rtl/feedback_comb_reverb.sv
test/feedback_comb_reverb_tb.sv
